[sv/rudp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rudp_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ETH,
        PH_VLAN,
        PH_IP4,
        PH_GRH,
        PH_UDP
    } phase_t;

    // Header fields in header order
    typedef enum logic [4:0] {
        FID_DMAC,
        FID_SMAC,
        FID_ETHERTYPE,
        FID_VLAN_TAG,
        FID_VLAN_TYPE,
        FID_IP4_VERSION,
        FID_IP4_IHL,
        FID_IP4_TOS,
        FID_IP4_TOT_LEN,
        FID_IP4_ID,
        FID_IP4_FRAG_OFF,
        FID_IP4_TTL,
        FID_IP4_PROTOCOL,
        FID_IP4_CSUM,
        FID_IP4_SADDR,
        FID_IP4_DADDR,
        FID_GRH_VERSION,
        FID_GRH_TCLASS,
        FID_GRH_FLOW_LABEL,
        FID_GRH_PAYLOAD_LEN,
        FID_GRH_NEXT_HDR,
        FID_GRH_HOP_LIMIT,
        FID_SGID_HI,
        FID_SGID_LO,
        FID_DGID_HI,
        FID_DGID_LO,
        FID_UDP_SPORT,
        FID_UDP_DPORT,
        FID_UDP_LENGTH,
        FID_UDP_CSUM
    } field_id_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_ETHERTYPE,
        ERR_IP_VERSION,
        ERR_NOT_UDP
    } err_code_t;

    localparam int POS_W = 6;

    localparam logic [POS_W-1:0] ETH_LAST_POS  = POS_W'(13);
    localparam logic [POS_W-1:0] VLAN_LAST_POS = POS_W'(3);
    localparam logic [POS_W-1:0] IP4_LAST_POS  = POS_W'(19);
    localparam logic [POS_W-1:0] GRH_LAST_POS  = POS_W'(39);
    localparam logic [POS_W-1:0] UDP_LAST_POS  = POS_W'(7);
    localparam logic [POS_W-1:0] IP4_PROTO_POS = POS_W'(9);
    localparam logic [POS_W-1:0] GRH_NHDR_POS  = POS_W'(6);

    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
    localparam logic [3:0]  IP4_VERSION = 4'd4;
    localparam logic [3:0]  IP6_VERSION = 4'd6;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        field_id_t   id;
        logic [63:0] value;
        err_code_t   err;
        logic        last;
    } field_res_t;

    // Up to two results from one byte, in order
    typedef struct packed {
        logic [1:0] cnt;
        field_res_t r0;
        field_res_t r1;
    } push_t;

    function automatic phase_t type_phase(input logic [15:0] etype, input logic tag_ok);
        phase_t ph;
        if (etype == ETYPE_VLAN && tag_ok) begin
            ph = PH_VLAN;
        end else if (etype == ETYPE_IPV4) begin
            ph = PH_IP4;
        end else if (etype == ETYPE_IPV6) begin
            ph = PH_GRH;
        end else begin
            ph = PH_IDLE;
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

[sv/rudp_parse.sv]
`timescale 1ns / 1ps
`default_nettype none

module rudp_parse
    import rudp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    input  wire logic        room_ok,
    output push_t            push
);

    logic             in_vld_reg;
    logic [7:0]       byte_reg;
    logic             first_reg;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [63:0]      acc_reg, acc_next;
    err_code_t        pend_reg, pend_next;

    phase_t           ph_base;
    logic [POS_W-1:0] pos_base;
    logic [63:0]      acc_base;
    err_code_t        pend_base;
    logic [63:0]      acc_new;
    logic             active;
    logic             fire;

    logic             f0_vld, f1_vld, err_vld;
    field_id_t        f0_id, f1_id;
    logic [63:0]      f0_val, f1_val;
    err_code_t        err_out;
    err_code_t        pend_upd;
    phase_t           ph_upd;
    field_res_t       res_f0, res_f1, res_err;

    assign fire    = in_vld_reg && room_ok;
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg  <= s_data_byte;
            first_reg <= s_first_byte;
        end
    end

    // A first byte restarts at Ethernet byte 0 with a cleared accumulator
    always_comb begin
        ph_base   = first_reg ? PH_ETH : phase_reg;
        pos_base  = first_reg ? '0 : pos_reg;
        acc_base  = first_reg ? '0 : acc_reg;
        pend_base = first_reg ? ERR_NONE : pend_reg;
        acc_new   = {acc_base[55:0], byte_reg};
        active    = (ph_base == PH_ETH) || (ph_base == PH_VLAN) || (ph_base == PH_IP4)
                    || (ph_base == PH_GRH) || (ph_base == PH_UDP);
    end

    // Field decode and header checks
    always_comb begin
        f0_vld   = 1'b0;
        f0_id    = FID_DMAC;
        f0_val   = '0;
        f1_vld   = 1'b0;
        f1_id    = FID_DMAC;
        f1_val   = '0;
        err_vld  = 1'b0;
        err_out  = ERR_NONE;
        pend_upd = pend_base;
        ph_upd   = ph_base;

        unique case (ph_base)
            PH_ETH: begin
                unique case (pos_base)
                    6'd5: begin
                        f0_vld = 1'b1; f0_id = FID_DMAC;
                        f0_val = {16'd0, acc_new[47:0]};
                    end
                    6'd11: begin
                        f0_vld = 1'b1; f0_id = FID_SMAC;
                        f0_val = {16'd0, acc_new[47:0]};
                    end
                    6'd13: begin
                        f0_vld = 1'b1; f0_id = FID_ETHERTYPE;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    default: ;
                endcase
                if (pos_base == ETH_LAST_POS) begin
                    ph_upd = type_phase(acc_new[15:0], 1'b1);
                    if (ph_upd == PH_IDLE) begin
                        err_vld = 1'b1;
                        err_out = ERR_ETHERTYPE;
                    end
                end
            end
            PH_VLAN: begin
                unique case (pos_base)
                    6'd1: begin
                        f0_vld = 1'b1; f0_id = FID_VLAN_TAG;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd3: begin
                        f0_vld = 1'b1; f0_id = FID_VLAN_TYPE;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    default: ;
                endcase
                if (pos_base == VLAN_LAST_POS) begin
                    ph_upd = type_phase(acc_new[15:0], 1'b0);
                    if (ph_upd == PH_IDLE) begin
                        err_vld = 1'b1;
                        err_out = ERR_ETHERTYPE;
                    end
                end
            end
            PH_IP4: begin
                unique case (pos_base)
                    6'd0: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_VERSION;
                        f0_val = {60'd0, acc_new[7:4]};
                        f1_vld = 1'b1; f1_id = FID_IP4_IHL;
                        f1_val = {60'd0, acc_new[3:0]};
                    end
                    6'd1: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_TOS;
                        f0_val = {56'd0, acc_new[7:0]};
                    end
                    6'd3: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_TOT_LEN;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd5: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_ID;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd7: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_FRAG_OFF;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd8: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_TTL;
                        f0_val = {56'd0, acc_new[7:0]};
                    end
                    6'd9: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_PROTOCOL;
                        f0_val = {56'd0, acc_new[7:0]};
                    end
                    6'd11: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_CSUM;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd15: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_SADDR;
                        f0_val = {32'd0, acc_new[31:0]};
                    end
                    6'd19: begin
                        f0_vld = 1'b1; f0_id = FID_IP4_DADDR;
                        f0_val = {32'd0, acc_new[31:0]};
                    end
                    default: ;
                endcase
                if (pos_base == '0 && byte_reg[7:4] != IP4_VERSION) begin
                    pend_upd = ERR_IP_VERSION;
                end
                if (pos_base == IP4_PROTO_POS && pend_base == ERR_NONE
                        && byte_reg != IP_PROTO_UDP) begin
                    pend_upd = ERR_NOT_UDP;
                end
                if (pos_base == IP4_LAST_POS) begin
                    if (pend_upd != ERR_NONE) begin
                        err_vld = 1'b1;
                        err_out = pend_upd;
                        ph_upd  = PH_IDLE;
                    end else begin
                        ph_upd = PH_UDP;
                    end
                end
            end
            PH_GRH: begin
                unique case (pos_base)
                    6'd0: begin
                        f0_vld = 1'b1; f0_id = FID_GRH_VERSION;
                        f0_val = {60'd0, acc_new[7:4]};
                    end
                    6'd1: begin
                        f0_vld = 1'b1; f0_id = FID_GRH_TCLASS;
                        f0_val = {56'd0, acc_new[11:4]};
                    end
                    6'd3: begin
                        f0_vld = 1'b1; f0_id = FID_GRH_FLOW_LABEL;
                        f0_val = {44'd0, acc_new[19:0]};
                    end
                    6'd5: begin
                        f0_vld = 1'b1; f0_id = FID_GRH_PAYLOAD_LEN;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd6: begin
                        f0_vld = 1'b1; f0_id = FID_GRH_NEXT_HDR;
                        f0_val = {56'd0, acc_new[7:0]};
                    end
                    6'd7: begin
                        f0_vld = 1'b1; f0_id = FID_GRH_HOP_LIMIT;
                        f0_val = {56'd0, acc_new[7:0]};
                    end
                    6'd15: begin
                        f0_vld = 1'b1; f0_id = FID_SGID_HI; f0_val = acc_new;
                    end
                    6'd23: begin
                        f0_vld = 1'b1; f0_id = FID_SGID_LO; f0_val = acc_new;
                    end
                    6'd31: begin
                        f0_vld = 1'b1; f0_id = FID_DGID_HI; f0_val = acc_new;
                    end
                    6'd39: begin
                        f0_vld = 1'b1; f0_id = FID_DGID_LO; f0_val = acc_new;
                    end
                    default: ;
                endcase
                if (pos_base == '0 && byte_reg[7:4] != IP6_VERSION) begin
                    pend_upd = ERR_IP_VERSION;
                end
                if (pos_base == GRH_NHDR_POS && pend_base == ERR_NONE
                        && byte_reg != IP_PROTO_UDP) begin
                    pend_upd = ERR_NOT_UDP;
                end
                if (pos_base == GRH_LAST_POS) begin
                    if (pend_upd != ERR_NONE) begin
                        err_vld = 1'b1;
                        err_out = pend_upd;
                        ph_upd  = PH_IDLE;
                    end else begin
                        ph_upd = PH_UDP;
                    end
                end
            end
            PH_UDP: begin
                unique case (pos_base)
                    6'd1: begin
                        f0_vld = 1'b1; f0_id = FID_UDP_SPORT;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd3: begin
                        f0_vld = 1'b1; f0_id = FID_UDP_DPORT;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd5: begin
                        f0_vld = 1'b1; f0_id = FID_UDP_LENGTH;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    6'd7: begin
                        f0_vld = 1'b1; f0_id = FID_UDP_CSUM;
                        f0_val = {48'd0, acc_new[15:0]};
                    end
                    default: ;
                endcase
                if (pos_base == UDP_LAST_POS) begin
                    ph_upd = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Pack results in order: fields first, error result after them
    always_comb begin
        res_f0  = '{id: f0_id, value: f0_val, err: ERR_NONE, last: (f0_id == FID_UDP_CSUM)};
        res_f1  = '{id: f1_id, value: f1_val, err: ERR_NONE, last: (f1_id == FID_UDP_CSUM)};
        res_err = '{id: FID_DMAC, value: '0, err: err_out, last: 1'b1};
        push.cnt = 2'd0;
        push.r0  = res_f0;
        push.r1  = res_f1;
        if (fire && active) begin
            priority if (f0_vld && f1_vld) begin
                push.cnt = 2'd2;
            end else if (f0_vld && err_vld) begin
                push.cnt = 2'd2;
                push.r1  = res_err;
            end else if (f0_vld) begin
                push.cnt = 2'd1;
            end else if (err_vld) begin
                push.cnt = 2'd1;
                push.r0  = res_err;
            end else begin
                push.cnt = 2'd0;
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        if (fire && active) begin
            acc_next = acc_new;
            if (ph_upd != ph_base) begin
                phase_next = ph_upd;
                pos_next   = '0;
                pend_next  = ERR_NONE;
            end else begin
                phase_next = ph_base;
                pos_next   = pos_base + POS_W'(1);
                pend_next  = pend_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            acc_reg   <= '0;
            pend_reg  <= ERR_NONE;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
        end
    end

    // Idle bytes without a first-byte mark leave no trace
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !first_reg && phase_reg == PH_IDLE) |-> (push.cnt == 2'd0))
        else $error("result produced while idle");

    // Every header position is left before it can run past the GRH length
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= GRH_LAST_POS)
        else $error("byte position out of range");

    // An error result always ends the header
    a_err_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && active && err_vld) |=> (phase_reg == PH_IDLE))
        else $error("parser kept running after error");

endmodule

`default_nettype wire

[sv/rudp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rudp_queue
    import rudp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire push_t       push,
    output logic             room_ok,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_field_id,
    output logic [63:0]      m_field_value,
    output logic [1:0]       m_error_code,
    output logic             m_last
);

    field_res_t        q_reg [QDEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_p1;
    logic              pop;
    field_res_t        head;

    assign wr_ptr_p1 = wr_ptr_reg + QPTR_W'(1);
    assign pop       = m_valid && m_ready;
    // Accept a byte only if both of its possible results fit
    assign room_ok   = count_reg <= QCNT_W'(QDEPTH - 2);

    assign head          = q_reg[rd_ptr_reg];
    assign m_valid       = count_reg != '0;
    assign m_field_id    = head.id;
    assign m_field_value = head.value;
    assign m_error_code  = head.err;
    assign m_last        = head.last;

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            q_reg[wr_ptr_p1] <= push.r1;
        end
    end

    always_comb begin
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.cnt);
        count_next  = count_reg + QCNT_W'(push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt != 2'd0) |-> (QCNT_W'(QDEPTH) - count_reg >= QCNT_W'(push.cnt)))
        else $error("push without room");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.cnt == 2'd0) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("pop did not drain queue");

endmodule

`default_nettype wire

[sv/roce_udp_header_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_data_byte[7:0], s_first_byte
// m_       out        m_valid/m_ready    m_field_id[4:0], m_field_value[63:0],
//                                        m_error_code[1:0], m_last
//
// One byte per clock is accepted while the queue has room; each byte is parsed
// combinationally from its input register and its results (up to two) land in a
// four-entry result queue.
// A byte waits in the input register while the queue has fewer than two free entries.
// aresetn is synchronous, active low; it returns the parser to idle and empties the queue.
// m_ stalls back up into s_ready only through the queue fill level.

module roce_udp_header_parser
    import rudp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_field_id,
    output logic [63:0]      m_field_value,
    output logic [1:0]       m_error_code,
    output logic             m_last
);

    push_t push;
    logic  room_ok;

    rudp_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_first_byte (s_first_byte),
        .room_ok      (room_ok),
        .push         (push)
    );

    rudp_queue u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .room_ok       (room_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_id    (m_field_id),
        .m_field_value (m_field_value),
        .m_error_code  (m_error_code),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
